// ===== sv/block_buffer_cache_lru_defines.svh =====
// ---------------------------------------------------------------------------
// Block buffer cache assertion macros
// Shared property forms used by the block buffer cache checks.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BBC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache package
// Sizes, codes and payload types shared by the block buffer cache modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

   // Number of buffer slots (2 to 32; the slot fields are five bits).
   localparam int NUM_BUFFERS = 32;
   localparam int SLOT_W      = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   // Wide enough for any slot index and for the slot count itself.
   localparam int WIDE_W      = 9;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FREE  = 2'd1,
      STATUS_COUNT    = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  slot_in;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [4:0] slot_out;
      logic       hit;
      logic       needs_read;
   } rsp_type;

   // One slot's stored record.
   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [31:0] stamp;
      logic [7:0]  count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic op_read;
      logic commit;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic in_is_get;
      logic scan_last;
   } stat_type;

   // Low five bits of a slot index for the result.
   function automatic logic [4:0] slot_to_out(input slot_idx_type s);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(s);
      return w[4:0];
   endfunction

endpackage

// ===== sv/bbc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache controller
// Sequences the slot scan for a get and the read-modify-write of other kinds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_ctrl import bbc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_OP_RD  = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.in_is_get ? ST_SCAN : ST_OP_RD;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_OP_RD: begin
            cmd.op_read = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/bbc_dp.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache datapath
// Slot record memory, tag and victim search registers, and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_dp import bbc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   req_type           req_ff;
   slot_idx_type      idx_ff;
   slot_idx_type      rd_idx_ff;
   logic              rd_pend_ff;
   logic              rd_written_ff;
   logic              rd_asg_ff;
   logic [NUM_BUFFERS-1:0] written_ff;
   logic [NUM_BUFFERS-1:0] asg_ff;

   logic              hit_ff;
   slot_idx_type      hit_slot_ff;
   entry_type         hit_entry_ff;
   logic              have_ff;
   slot_idx_type      vic_slot_ff;
   logic [31:0]       best_stamp_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [ENTRY_W-1:0] ram_rdata;
   entry_type         rd_entry;
   logic              rd_en;
   slot_idx_type      rd_addr;
   logic [WIDE_W-1:0] slot_wide;
   logic              slot_in_range;
   slot_idx_type      op_addr;
   logic              match;
   logic              free_better;

   logic              wr_en;
   slot_idx_type      wr_addr;
   entry_type         wr_entry;
   logic              set_asg;
   rsp_type           rsp_in;
   logic [7:0]        new_count;

   // Status for the controller.
   assign stat.in_is_get = (req_data.kind == KIND_GET);
   assign stat.scan_last = (idx_ff == SLOT_W'(NUM_BUFFERS - 1));

   // Slot addressed by release, pin and unpin.
   assign slot_wide     = WIDE_W'(req_ff.slot_in);
   assign slot_in_range = (slot_wide < WIDE_W'(NUM_BUFFERS));
   assign op_addr       = slot_wide[SLOT_W-1:0];

   // Read address: the scan index or the addressed slot.
   assign rd_en   = cmd.scan_step | cmd.op_read;
   assign rd_addr = cmd.scan_step ? idx_ff : op_addr;

   bbc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BUFFERS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // A record never written reads as all zero.
   assign rd_entry = rd_written_ff ? entry_type'(ram_rdata) : '0;

   // Tag compare and victim compare on the record just read.
   assign match = rd_asg_ff && (rd_entry.device == req_ff.device) &&
                  (rd_entry.block == req_ff.block_number);
   assign free_better = (rd_entry.count == 8'd0) &&
                        (!have_ff || (rd_entry.stamp < best_stamp_ff));

   // Request latch, scan index and read pipeline flags.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (rd_en) begin
         rd_idx_ff     <= rd_addr;
         rd_written_ff <= written_ff[rd_addr];
         rd_asg_ff     <= asg_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_step;
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
      end
   end

   // Scan accumulators: first matching slot and oldest free slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         have_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff  <= 1'b0;
         have_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         if (match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (free_better) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         if (match && !hit_ff) begin
            hit_slot_ff  <= rd_idx_ff;
            hit_entry_ff <= rd_entry;
         end
         if (free_better) begin
            vic_slot_ff   <= rd_idx_ff;
            best_stamp_ff <= rd_entry.stamp;
         end
      end
   end

   // Commit: record update and result. The data-valid mark of a slot is set
   // whenever the slot is tagged, so the tag-assigned bit stands for it.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = op_addr;
      wr_entry  = rd_entry;
      set_asg   = 1'b0;
      rsp_in    = '0;
      new_count = 8'd0;
      if (cmd.commit) begin
         if (req_ff.kind == KIND_GET) begin
            if (hit_ff) begin
               if (hit_entry_ff.count == COUNT_MAX) begin
                  rsp_in.status = STATUS_COUNT;
               end else begin
                  wr_en             = 1'b1;
                  wr_addr           = hit_slot_ff;
                  wr_entry          = hit_entry_ff;
                  wr_entry.count    = hit_entry_ff.count + 8'd1;
                  rsp_in.status     = STATUS_OK;
                  rsp_in.slot_out   = slot_to_out(hit_slot_ff);
                  rsp_in.hit        = 1'b1;
                  rsp_in.needs_read = 1'b0;
               end
            end else if (have_ff) begin
               wr_en             = 1'b1;
               set_asg           = 1'b1;
               wr_addr           = vic_slot_ff;
               wr_entry.device   = req_ff.device;
               wr_entry.block    = req_ff.block_number;
               wr_entry.stamp    = best_stamp_ff;
               wr_entry.count    = 8'd1;
               rsp_in.status     = STATUS_OK;
               rsp_in.slot_out   = slot_to_out(vic_slot_ff);
               rsp_in.needs_read = 1'b1;
            end else begin
               rsp_in.status = STATUS_NO_FREE;
            end
         end else if (slot_in_range) begin
            if (req_ff.kind == KIND_PIN) begin
               if (rd_entry.count == COUNT_MAX) begin
                  rsp_in.status = STATUS_COUNT;
               end else begin
                  wr_en          = 1'b1;
                  wr_entry.count = rd_entry.count + 8'd1;
               end
            end else begin
               if (rd_entry.count == 8'd0) begin
                  rsp_in.status = STATUS_COUNT;
               end else begin
                  new_count      = rd_entry.count - 8'd1;
                  wr_en          = 1'b1;
                  wr_entry.count = new_count;
                  if ((req_ff.kind == KIND_RELEASE) && (new_count == 8'd0)) begin
                     wr_entry.stamp = req_ff.now;
                  end
               end
            end
         end
      end
   end

   // Written and tag-assigned bits per slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         asg_ff     <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
         if (set_asg) begin
            asg_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Result register: one cycle strobe per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/block_buffer_cache_lru.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache with least-recently-released replacement
// Tag table for disk block buffers with reference counts and release stamps.
// ---------------------------------------------------------------------------
//   Channel   Ports                     Transfer
//   request   start, busy, req_data     start high while busy low
//   response  rsp_valid, rsp_data       one cycle strobe, always taken
//
// A get sweeps the single read port of the slot record memory one slot a cycle,
// then writes the hit or victim record and registers its result strobe.
// Release, pin and unpin read the addressed slot, then write it and register the result.
// Reset is synchronous; per-slot written and tagged bits clear at once, so no
// clearing pass runs. The receiver cannot stall; busy alone holds off requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_buffer_cache_lru_defines.svh"

module block_buffer_cache_lru import bbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   bbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bbc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result is shown only once the controller is back in idle.
   `BBC_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy, "result strobe while busy")
   // An accepted transaction makes the block busy.
   `BBC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
   // Each transaction gives a single result strobe.
   `BBC_ASSERT_NEXT(a_single_rsp, rsp_valid, !rsp_valid, "result strobe repeated")
   // An error result carries no slot, hit or read indication.
   `BBC_ASSERT_SAME(a_err_zero, rsp_valid && (rsp_data.status != STATUS_OK),
      (rsp_data.slot_out == 5'd0) && !rsp_data.hit && !rsp_data.needs_read,
      "error result with nonzero fields")

endmodule

// ===== dv/tb_block_buffer_cache_lru.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block buffer cache testbench
// Drives get, release, pin and unpin transactions into the buffer tag table.
// It predicts each transaction's result with its own model of the slots:
// tags, reference counts, release stamps and data-valid marks. Every result
// strobe is checked field by field against that prediction. A short directed
// run comes first. Random episodes follow, with lookups, release sweeps,
// pin/unpin mixes, table floods, noise, and one climb to the count limit.
// ---------------------------------------------------------------------------
module tb_block_buffer_cache_lru;
   import bbc_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int RESET_LEN   = 6;
   localparam int ITEM_TARGET = 1250;
   localparam int MAX_GAP     = 18;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 40;
   localparam int KEY_POOL    = 40;

   // A queued request with the idle cycles that precede it.
   typedef struct packed {
      req_type    req;
      logic [4:0] gap;
   } queued_req_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predicted slot state.
   logic [7:0]  slot_dev    [NUM_BUFFERS];
   logic [31:0] slot_blk    [NUM_BUFFERS];
   logic        slot_tagged [NUM_BUFFERS];
   logic [7:0]  slot_refs   [NUM_BUFFERS];
   logic [31:0] slot_stamp  [NUM_BUFFERS];
   logic        slot_loaded [NUM_BUFFERS];

   // Keys that recur, so that lookups hit.
   logic [7:0]  pool_dev [KEY_POOL];
   logic [31:0] pool_blk [KEY_POOL];

   queued_req_type request_backlog[$];
   rsp_type        expected_replies[$];

   int issued_cnt    = 0;
   int presented_cnt = 0;
   int accepted_cnt  = 0;
   int replies_seen  = 0;
   int mismatch_cnt  = 0;
   int cycle_cnt     = 0;
   int hit_cnt       = 0;
   int miss_cnt      = 0;
   int no_free_cnt   = 0;
   int limit_cnt     = 0;
   int pace_mode     = 0;

   queued_req_type staged;
   logic           have_staged = 1'b0;
   int             idle_left   = 0;

   block_buffer_cache_lru u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_HALF);
      clock = 1'b1;
      #(CLOCK_HALF);
   end

   // Prints one line per disagreement, up to a cap, and counts them all.
   task automatic flag_mismatch(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= PRINT_CAP) begin
         $display("ERROR cycle %0d: %s", cycle_cnt, what);
      end
   endtask

   // Applies one transaction to the predicted table and returns its result.
   function automatic rsp_type buffer_table_step(input req_type r);
      rsp_type ans;
      int      i;
      int      s;
      int      victim;
      ans = '0;
      ans.status = STATUS_OK;
      if (r.kind == KIND_GET) begin
         s = -1;
         for (i = 0; i < NUM_BUFFERS; i++) begin
            if (s < 0 && slot_tagged[i] && slot_dev[i] == r.device &&
                slot_blk[i] == r.block_number) begin
               s = i;
            end
         end
         if (s >= 0) begin
            // Hit: bump the count unless it is already saturated.
            if (slot_refs[s] == COUNT_MAX) begin
               ans.status = STATUS_COUNT;
            end else begin
               slot_refs[s]   = slot_refs[s] + 8'd1;
               ans.slot_out   = s[4:0];
               ans.hit        = 1'b1;
               ans.needs_read = !slot_loaded[s];
               slot_loaded[s] = 1'b1;
            end
         end else begin
            // Miss: the oldest unreferenced slot wins, lowest index on a tie.
            victim = -1;
            for (i = 0; i < NUM_BUFFERS; i++) begin
               if (slot_refs[i] == 8'd0 &&
                   (victim < 0 || slot_stamp[i] < slot_stamp[victim])) begin
                  victim = i;
               end
            end
            if (victim < 0) begin
               ans.status = STATUS_NO_FREE;
            end else begin
               slot_dev[victim]    = r.device;
               slot_blk[victim]    = r.block_number;
               slot_tagged[victim] = 1'b1;
               slot_refs[victim]   = 8'd1;
               slot_loaded[victim] = 1'b1;
               ans.slot_out        = victim[4:0];
               ans.needs_read      = 1'b1;
            end
         end
      end else if (int'(r.slot_in) < NUM_BUFFERS) begin
         s = int'(r.slot_in);
         if (r.kind == KIND_PIN) begin
            if (slot_refs[s] == COUNT_MAX) begin
               ans.status = STATUS_COUNT;
            end else begin
               slot_refs[s] = slot_refs[s] + 8'd1;
            end
         end else if (slot_refs[s] == 8'd0) begin
            ans.status = STATUS_COUNT;
         end else begin
            slot_refs[s] = slot_refs[s] - 8'd1;
            if (r.kind == KIND_RELEASE && slot_refs[s] == 8'd0) begin
               slot_stamp[s] = r.now;
            end
         end
      end
      return ans;
   endfunction

   // Check result strobes first, then record any transaction taken at this edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = rsp_data;
            replies_seen++;
            if (expected_replies.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                       replies_seen));
            end else begin
               want = expected_replies.pop_front();
               if (got.status !== want.status)
                  flag_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                          replies_seen, got.status, want.status));
               if (got.slot_out !== want.slot_out)
                  flag_mismatch($sformatf("result %0d slot_out: got %0d, expected %0d",
                                          replies_seen, got.slot_out, want.slot_out));
               if (got.hit !== want.hit)
                  flag_mismatch($sformatf("result %0d hit: got %b, expected %b",
                                          replies_seen, got.hit, want.hit));
               if (got.needs_read !== want.needs_read)
                  flag_mismatch($sformatf("result %0d needs_read: got %b, expected %b",
                                          replies_seen, got.needs_read, want.needs_read));
            end
         end
         if (start && !busy) begin
            want = buffer_table_step(req_data);
            expected_replies.push_back(want);
            accepted_cnt++;
            if (want.status == STATUS_NO_FREE) no_free_cnt++;
            else if (want.status == STATUS_COUNT) limit_cnt++;
            else if (req_data.kind == KIND_GET && want.hit) hit_cnt++;
            else if (req_data.kind == KIND_GET) miss_cnt++;
         end
      end
   end

   // Present queued requests after their idle gap; hold each until it is taken.
   always @(negedge clock) begin : driver
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted_cnt == presented_cnt) begin
         if (!have_staged && request_backlog.size() != 0) begin
            staged      = request_backlog.pop_front();
            have_staged = 1'b1;
            idle_left   = int'(staged.gap);
         end
         if (have_staged && idle_left == 0) begin
            req_data    <= staged.req;
            start       <= 1'b1;
            presented_cnt++;
            have_staged = 1'b0;
         end else begin
            start <= 1'b0;
            if (have_staged) idle_left--;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Queues one transaction; the idle gap before it follows the current pace.
   task automatic push_op(input kind_type k, input logic [7:0] dev, input logic [31:0] blk,
                          input logic [4:0] slot, input logic [31:0] tick);
      queued_req_type e;
      e.req.kind         = k;
      e.req.device       = dev;
      e.req.block_number = blk;
      e.req.slot_in      = slot;
      e.req.now          = tick;
      case (pace_mode)
         0:       e.gap = 5'($urandom_range(0, MAX_GAP));
         1:       e.gap = 5'd0;
         default: e.gap = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(1, MAX_GAP)) : 5'd0;
      endcase
      request_backlog.push_back(e);
      issued_cnt++;
   endtask

   task automatic push_get(input logic [7:0] dev, input logic [31:0] blk);
      push_op(KIND_GET, dev, blk, 5'($urandom), $urandom());
   endtask

   // Mostly recurring keys, sometimes a fresh one.
   task automatic push_pool_get();
      int k;
      k = $urandom_range(0, KEY_POOL - 1);
      if ($urandom_range(0, 9) < 7) push_get(pool_dev[k], pool_blk[k]);
      else push_get(8'($urandom), $urandom());
   endtask

   // Release stamps: small values for ties, the top value, or anything.
   function automatic logic [31:0] pick_tick();
      case ($urandom_range(0, 9))
         0, 1, 2: return 32'($urandom_range(0, 3));
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Usually a slot that holds references, now and then any slot.
   function automatic logic [4:0] held_slot();
      int cand[$];
      int i;
      for (i = 0; i < NUM_BUFFERS; i++) begin
         if (slot_refs[i] != 8'd0) cand.push_back(i);
      end
      if (cand.size() == 0 || $urandom_range(0, 5) == 0)
         return 5'($urandom_range(0, NUM_BUFFERS - 1));
      return 5'(cand[$urandom_range(0, cand.size() - 1)]);
   endfunction

   // Returns at a falling edge once every transaction is taken and answered.
   task automatic wait_quiet();
      while (accepted_cnt != issued_cnt || expected_replies.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int   i;
      int   n;
      int   s;
      int   pick;
      logic found;
      logic burst_done;

      burst_done = 1'b0;
      for (i = 0; i < NUM_BUFFERS; i++) begin
         slot_dev[i]    = '0;
         slot_blk[i]    = '0;
         slot_tagged[i] = 1'b0;
         slot_refs[i]   = '0;
         slot_stamp[i]  = '0;
         slot_loaded[i] = 1'b0;
      end
      // Neighboring pool entries share a block number on different devices.
      for (i = 0; i < KEY_POOL; i++) begin
         pool_dev[i] = 8'(i % 3);
         pool_blk[i] = (i < 20) ? 32'(i / 2) : $urandom();
      end
      pool_dev[KEY_POOL - 1] = 8'hFF;
      pool_blk[KEY_POOL - 1] = 32'hFFFF_FFFF;

      repeat (RESET_LEN) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Directed: first misses, hit, device mismatch, final release stamping,
      // underflow, pins on an untagged slot and a tagged one, hit on an unreferenced slot, and
      // a stamp tie between a released slot and untagged ones.
      pace_mode = 0;
      push_get(8'h00, 32'h0000_0000);
      push_get(8'h00, 32'h0000_0000);
      push_get(8'hFF, 32'hFFFF_FFFF);
      push_get(8'h01, 32'h0000_0000);
      push_op(KIND_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
      push_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
      push_op(KIND_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
      push_op(KIND_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0005);
      push_op(KIND_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
      push_op(KIND_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000);
      push_op(KIND_PIN, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0000);
      push_op(KIND_UNPIN, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0000);
      push_get(8'h00, 32'h0000_0000);
      push_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0007);
      push_op(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0000);
      push_get(8'h05, 32'h0000_0005);
      push_get(8'h01, 32'h0000_0000);
      push_get(8'h00, 32'h0000_0000);
      wait_quiet();

      // Random episodes; the sender drains all results between episodes.
      while (issued_cnt < ITEM_TARGET) begin
         @(posedge clock);
         case ($urandom_range(0, 3))
            0, 1:    pace_mode = 0;
            2:       pace_mode = 1;
            default: pace_mode = 2;
         endcase
         if (!burst_done && issued_cnt >= 500) begin
            // Climb one slot to the count limit, overflow it by pin and by
            // lookup, then walk it back down to zero.
            pick  = $urandom_range(0, NUM_BUFFERS - 1);
            s     = pick;
            found = 1'b0;
            for (i = 0; i < NUM_BUFFERS; i++) begin
               if (!found && slot_tagged[(pick + i) % NUM_BUFFERS]) begin
                  s     = (pick + i) % NUM_BUFFERS;
                  found = 1'b1;
               end
            end
            repeat (int'(COUNT_MAX - slot_refs[s]) + 1)
               push_op(KIND_PIN, 8'($urandom), $urandom(), 5'(s), $urandom());
            if (found) push_get(slot_dev[s], slot_blk[s]);
            for (i = 0; i < 255; i++)
               push_op((i == 254 || $urandom_range(0, 1) == 1) ? KIND_RELEASE : KIND_UNPIN,
                       8'($urandom), $urandom(), 5'(s), pick_tick());
            burst_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // Lookups with the odd release mixed in.
                  n = $urandom_range(4, 16);
                  repeat (n) begin
                     if ($urandom_range(0, 3) == 0)
                        push_op(KIND_RELEASE, 8'($urandom), $urandom(), held_slot(),
                                pick_tick());
                     else
                        push_pool_get();
                  end
               end
               4, 5: begin
                  // Release sweep over held slots, plus one stray release.
                  for (i = 0; i < NUM_BUFFERS; i++) begin
                     if (slot_refs[i] != 8'd0 && $urandom_range(0, 2) != 0) begin
                        repeat ((slot_refs[i] > 8'd1 && $urandom_range(0, 1) == 1) ? 2 : 1)
                           push_op(KIND_RELEASE, 8'($urandom), $urandom(), 5'(i),
                                   pick_tick());
                     end
                  end
                  push_op(KIND_RELEASE, 8'($urandom), $urandom(),
                          5'($urandom_range(0, NUM_BUFFERS - 1)), pick_tick());
               end
               6: begin
                  n = $urandom_range(6, 12);
                  repeat (n)
                     push_op(($urandom_range(0, 1) == 1) ? KIND_PIN : KIND_UNPIN,
                             8'($urandom), $urandom(), held_slot(), $urandom());
               end
               7: begin
                  // Flood with fresh keys until the table runs out of buffers.
                  n = $urandom_range(34, 40);
                  repeat (n) push_get(8'($urandom), $urandom());
               end
               default: begin
                  n = $urandom_range(4, 10);
                  repeat (n)
                     push_op(kind_type'($urandom_range(0, 3)), 8'($urandom), $urandom(),
                             5'($urandom), $urandom());
               end
            endcase
         end
         wait_quiet();
      end

      // Let any stray strobe show up before the verdict.
      repeat (NUM_BUFFERS + 8) @(posedge clock);
      $display("Covered %0d transactions: %0d lookup hits, %0d misses, %0d with no free buffer.",
               accepted_cnt, hit_cnt, miss_cnt, no_free_cnt);
      $display("Count overflow or underflow seen %0d times; %0d field errors recorded.",
               limit_cnt, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_ctrl.sv
sv/bbc_dp.sv
sv/block_buffer_cache_lru.sv
dv/tb_block_buffer_cache_lru.sv
